/* rtl/sfha_pkg.sv */
// Shared types, constants and defaults for the segregated-fit heap allocator.
// Used by every module of the block; no dependencies.
package sfha_pkg;

    // Heap word store geometry (only the low 17 bits of a word ever matter)
    localparam int WORD_W     = 17;
    localparam int ADDR_W     = 13;
    localparam int HEAP_WORDS = 8192;
    localparam int OFF_W      = 17;

    // Block layout
    localparam logic [16:0] MIN_BLOCK  = 17'd32;
    localparam logic [16:0] WORD_BYTES = 17'd8;
    localparam int F_ALLOC = 2;
    localparam int F_PREV  = 1;
    localparam int F_QUICK = 0;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NULL   = 2'd1;
    localparam logic [1:0] ST_OOM    = 2'd2;
    localparam logic [1:0] ST_BADPTR = 2'd3;

    // Configuration
    localparam logic [3:0] QCAP_RESET = 4'd5;

    // Parameter defaults
    localparam int DEF_PAGE_BYTES       = 4096;
    localparam int DEF_MAX_PAGES        = 16;
    localparam int DEF_NUM_QUICK_SIZES  = 10;
    localparam int DEF_NUM_SIZE_CLASSES = 10;

    // Heap memory access, one write and one read port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Finished transaction from the engine
    typedef struct packed {
        logic        valid;
        logic [15:0] offset;
        logic [1:0]  status;
    } t_rsp;

endpackage

/* rtl/sfha_if.sv */
// Request and response channel interfaces of the heap allocator.
// Depends on nothing; payload widths follow the block's fields.
interface sfha_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [16:0] request_size;
    logic [15:0] payload_offset;
    modport source (output valid, op, request_size, payload_offset, input ready);
    modport sink   (input valid, op, request_size, payload_offset, output ready);
endinterface

interface sfha_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_offset;
    logic [1:0]  status;
    modport source (output valid, result_offset, status, input ready);
    modport sink   (input valid, result_offset, status, output ready);
endinterface

/* rtl/sfha_heap_mem.sv */
// Heap word memory: one write port, one registered read port.
// Depends on sfha_pkg for geometry and the request struct.
module sfha_heap_mem (
    input  logic                         i_clk,
    input  sfha_pkg::t_mem_req           i_req,
    output logic [sfha_pkg::WORD_W-1:0]  o_rdata
);

    logic [sfha_pkg::WORD_W-1:0] r_mem [sfha_pkg::HEAP_WORDS];
    logic [sfha_pkg::WORD_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sfha_engine.sv */
// Allocator sequencer: walks lists and boundary tags through the heap memory.
// Depends on sfha_pkg; drives sfha_heap_mem through a t_mem_req struct.
module sfha_engine #(
    parameter int PAGE_BYTES       = sfha_pkg::DEF_PAGE_BYTES,
    parameter int MAX_PAGES        = sfha_pkg::DEF_MAX_PAGES,
    parameter int NUM_QUICK_SIZES  = sfha_pkg::DEF_NUM_QUICK_SIZES,
    parameter int NUM_SIZE_CLASSES = sfha_pkg::DEF_NUM_SIZE_CLASSES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [16:0]                 i_request_size,
    input  logic [15:0]                 i_payload_offset,
    input  logic [3:0]                  i_qcap,
    input  logic                        i_out_free,
    output sfha_pkg::t_rsp              o_done,
    output sfha_pkg::t_mem_req          o_mem,
    input  logic [sfha_pkg::WORD_W-1:0] i_rdata
);

    localparam int CW = $clog2(NUM_SIZE_CLASSES);
    localparam int QW = (NUM_QUICK_SIZES > 1) ? $clog2(NUM_QUICK_SIZES) : 1;
    localparam int LIM_RAW = PAGE_BYTES * MAX_PAGES;
    localparam int LIMIT_I = (LIM_RAW > 65536) ? 65536 : LIM_RAW;
    localparam logic [17:0] LIMIT  = 18'(LIMIT_I);
    localparam logic [16:0] PAGE   = 17'(PAGE_BYTES);
    localparam logic [16:0] FSZ    = 17'(PAGE_BYTES - 40);
    localparam logic [13:0] STEP_MAX = 14'(sfha_pkg::HEAP_WORDS);

    // State codes
    localparam logic [5:0] S_IDLE = 6'd0,  S_DONE = 6'd1,  S_MAL = 6'd2,  S_MQ1 = 6'd3;
    localparam logic [5:0] S_MQ2  = 6'd4,  S_SU0  = 6'd5,  S_SU1 = 6'd6,  S_SU2 = 6'd7;
    localparam logic [5:0] S_SU3  = 6'd8,  S_FS   = 6'd9,  S_FH  = 6'd10, S_FT  = 6'd11;
    localparam logic [5:0] S_FC   = 6'd12, S_FN   = 6'd13, S_G0  = 6'd14, S_G1  = 6'd15;
    localparam logic [5:0] S_G2   = 6'd16, S_G3   = 6'd17, S_PL0 = 6'd18, S_PL1 = 6'd19;
    localparam logic [5:0] S_PL2  = 6'd20, S_PL3  = 6'd21, S_PL4 = 6'd22, S_PL5 = 6'd23;
    localparam logic [5:0] S_LR0  = 6'd24, S_LR1  = 6'd25, S_LR2 = 6'd26, S_LR3 = 6'd27;
    localparam logic [5:0] S_LR4  = 6'd28, S_LP0  = 6'd29, S_LP1 = 6'd30, S_LP2 = 6'd31;
    localparam logic [5:0] S_LP3  = 6'd32, S_SN0  = 6'd33, S_SN1 = 6'd34, S_SN2 = 6'd35;
    localparam logic [5:0] S_SN3  = 6'd36, S_CP0  = 6'd37, S_CP1 = 6'd38, S_CP2 = 6'd39;
    localparam logic [5:0] S_CP3  = 6'd40, S_CP4  = 6'd41, S_CP5 = 6'd42, S_CP6 = 6'd43;
    localparam logic [5:0] S_CP7  = 6'd44, S_CP8  = 6'd45, S_RL0 = 6'd46, S_RL1 = 6'd47;
    localparam logic [5:0] S_RL2  = 6'd48, S_RL3  = 6'd49, S_FREE = 6'd50, S_V1 = 6'd51;
    localparam logic [5:0] S_V2   = 6'd52, S_V3   = 6'd53, S_VOK = 6'd54, S_FL0 = 6'd55;
    localparam logic [5:0] S_FL1  = 6'd56, S_FL2  = 6'd57, S_FL3 = 6'd58, S_FL4 = 6'd59;

    function automatic logic [sfha_pkg::ADDR_W-1:0] widx(input logic [16:0] off);
        return off[15:3];
    endfunction

    function automatic logic [16:0] szf(input logic [16:0] w);
        return {w[16:3], 3'b000};
    endfunction

    function automatic logic [CW-1:0] class_of(input logic [16:0] s);
        logic [CW-1:0] c;
        c = CW'(NUM_SIZE_CLASSES - 1);
        for (int i = NUM_SIZE_CLASSES - 2; i >= 1; i--) begin
            if ({3'b000, s} <= (20'd32 << i)) c = CW'(i);
        end
        if (s <= sfha_pkg::MIN_BLOCK) c = '0;
        return c;
    endfunction

    // Valid flag on top, quick list index below
    function automatic logic [QW:0] quick_of(input logic [16:0] s);
        logic [16:0] d;
        logic        v;
        d = s - sfha_pkg::MIN_BLOCK;
        v = (s >= sfha_pkg::MIN_BLOCK) && (d[2:0] == 3'b000) &&
            ({3'b000, d[16:3]} < 17'(NUM_QUICK_SIZES));
        return {v, d[QW+2:3]};
    endfunction

    // Control registers
    logic [5:0]    r_state, n_state;
    logic [1:0]    r_sp, n_sp;
    logic [5:0]    r_stk [4];
    logic [5:0]    n_stk [4];
    logic [16:0]   r_hend, n_hend;
    logic [15:0]   r_epi, n_epi;
    logic [15:0]   r_chead [NUM_SIZE_CLASSES];
    logic [15:0]   n_chead [NUM_SIZE_CLASSES];
    logic [15:0]   r_qhead [NUM_QUICK_SIZES];
    logic [15:0]   n_qhead [NUM_QUICK_SIZES];
    logic [3:0]    r_qlen [NUM_QUICK_SIZES];
    logic [3:0]    n_qlen [NUM_QUICK_SIZES];

    // Working registers
    logic [16:0] r_h, n_h, r_n, n_n, r_sz, n_sz, r_w, n_w, r_b, n_b, r_bs, n_bs;
    logic [16:0] r_asize, n_asize, r_rsz, n_rsz, r_fh, n_fh;
    logic [16:0] r_ch, n_ch, r_cs, n_cs, r_cst, n_cst;
    logic [15:0] r_nx, n_nx, r_pv, n_pv, r_old, n_old, r_off, n_off, r_res, n_res;
    logic [1:0]  r_stat, n_stat;
    logic [CW-1:0] r_c, n_c, r_fc, n_fc;
    logic [QW-1:0] r_q, n_q;
    logic [13:0] r_steps, n_steps;
    logic        r_on, n_on, r_prev, n_prev;

    sfha_pkg::t_mem_req mem;
    logic [1:0]  sp_m1;
    logic [16:0] rsz_w, a_pad, a_sz, h_tmp, ps;
    logic [QW:0] qa;
    logic [CW-1:0] cl;
    logic [16:0] wv;

    assign sp_m1 = r_sp - 2'd1;
    assign o_mem = mem;
    assign o_ready = (r_state == S_IDLE);
    assign o_done.valid  = (r_state == S_DONE) && i_out_free;
    assign o_done.offset = r_res;
    assign o_done.status = r_stat;

    // Sequencer next state and memory access
    always_comb begin
        n_state = r_state; n_sp = r_sp; n_stk = r_stk;
        n_hend = r_hend; n_epi = r_epi;
        n_chead = r_chead; n_qhead = r_qhead; n_qlen = r_qlen;
        n_h = r_h; n_n = r_n; n_sz = r_sz; n_w = r_w; n_b = r_b; n_bs = r_bs;
        n_asize = r_asize; n_rsz = r_rsz; n_fh = r_fh;
        n_ch = r_ch; n_cs = r_cs; n_cst = r_cst;
        n_nx = r_nx; n_pv = r_pv; n_old = r_old; n_off = r_off; n_res = r_res;
        n_stat = r_stat; n_c = r_c; n_fc = r_fc; n_q = r_q; n_steps = r_steps;
        n_on = r_on; n_prev = r_prev;
        mem = '0;
        rsz_w = r_rsz + sfha_pkg::WORD_BYTES;
        a_pad = rsz_w + 17'd7;
        a_sz  = (rsz_w < sfha_pkg::MIN_BLOCK) ? sfha_pkg::MIN_BLOCK
                                               : {a_pad[16:3], 3'b000};
        qa    = quick_of(a_sz);
        h_tmp = {1'b0, r_off} - sfha_pkg::WORD_BYTES;
        ps    = szf(i_rdata);
        cl    = class_of(szf(i_rdata));
        wv    = i_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_rsz = i_request_size;
                    n_off = i_payload_offset;
                    n_state = (i_op == sfha_pkg::OP_FREE) ? S_FREE : S_MAL;
                end
            end
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end

            // Allocate: size check, quick list pop
            S_MAL: begin
                n_asize = a_sz;
                if (r_rsz == '0) begin
                    n_res = '0; n_stat = sfha_pkg::ST_NULL; n_state = S_DONE;
                end else if (qa[QW] && (r_qlen[qa[QW-1:0]] != 4'd0)) begin
                    n_q = qa[QW-1:0];
                    n_b = {1'b0, r_qhead[qa[QW-1:0]]};
                    n_qlen[qa[QW-1:0]] = r_qlen[qa[QW-1:0]] - 4'd1;
                    mem.re = 1'b1;
                    mem.raddr = widx({1'b0, r_qhead[qa[QW-1:0]]} + 17'd8);
                    n_state = S_MQ1;
                end else if (r_hend == '0) begin
                    n_state = S_SU0;
                end else begin
                    n_state = S_FS;
                end
            end
            S_MQ1: begin
                n_qhead[r_q] = (r_qlen[r_q] != 4'd0) ? i_rdata[15:0] : 16'd0;
                mem.re = 1'b1; mem.raddr = widx(r_b);
                n_state = S_MQ2;
            end
            S_MQ2: begin
                wv[sfha_pkg::F_QUICK] = 1'b0;
                mem.we = 1'b1; mem.waddr = widx(r_b); mem.wdata = wv;
                n_res = 16'(r_b + 17'd8); n_stat = sfha_pkg::ST_OK;
                n_state = S_DONE;
            end

            // First-use heap layout
            S_SU0: begin
                mem.we = 1'b1; mem.waddr = widx(17'd0);
                mem.wdata = sfha_pkg::MIN_BLOCK | 17'd4;
                n_hend = PAGE;
                n_epi = 16'(PAGE - sfha_pkg::WORD_BYTES);
                n_state = S_SU1;
            end
            S_SU1: begin
                mem.we = 1'b1; mem.waddr = widx({1'b0, r_epi}); mem.wdata = 17'd4;
                n_state = S_SU2;
            end
            S_SU2: begin
                mem.we = 1'b1; mem.waddr = widx(sfha_pkg::MIN_BLOCK);
                mem.wdata = FSZ | 17'd2;
                n_state = S_SU3;
            end
            S_SU3: begin
                mem.we = 1'b1;
                mem.waddr = widx(sfha_pkg::MIN_BLOCK + FSZ - sfha_pkg::WORD_BYTES);
                mem.wdata = FSZ | 17'd2;
                for (int i = 0; i < NUM_SIZE_CLASSES; i++) n_chead[i] = '0;
                n_h = sfha_pkg::MIN_BLOCK;
                n_stk[r_sp] = S_FS; n_sp = r_sp + 2'd1;
                n_state = S_LP0;
            end

            // First fit over the class lists
            S_FS: begin
                n_fc = class_of(r_asize);
                n_state = S_FH;
            end
            S_FH: begin
                n_b = {1'b0, r_chead[r_fc]};
                n_steps = '0;
                n_state = S_FT;
            end
            S_FT: begin
                if (r_b == '0 || r_steps == STEP_MAX) begin
                    if (r_fc == CW'(NUM_SIZE_CLASSES - 1)) begin
                        n_state = S_G0;
                    end else begin
                        n_fc = r_fc + CW'(1);
                        n_state = S_FH;
                    end
                end else begin
                    mem.re = 1'b1; mem.raddr = widx(r_b);
                    n_state = S_FC;
                end
            end
            S_FC: begin
                if (ps >= r_asize) begin
                    n_state = S_PL0;
                end else begin
                    mem.re = 1'b1; mem.raddr = widx(r_b + 17'd8);
                    n_state = S_FN;
                end
            end
            S_FN: begin
                n_b = {1'b0, i_rdata[15:0]};
                n_steps = r_steps + 14'd1;
                n_state = S_FT;
            end

            // Grow by one page
            S_G0: begin
                if ({1'b0, r_hend} + {1'b0, PAGE} > LIMIT) begin
                    n_res = '0; n_stat = sfha_pkg::ST_OOM; n_state = S_DONE;
                end else begin
                    n_n = {1'b0, r_epi};
                    n_hend = r_hend + PAGE;
                    n_epi = 16'(r_hend + PAGE - sfha_pkg::WORD_BYTES);
                    mem.we = 1'b1;
                    mem.waddr = widx(r_hend + PAGE - sfha_pkg::WORD_BYTES);
                    mem.wdata = 17'd4;
                    n_state = S_G1;
                end
            end
            S_G1: begin
                mem.re = 1'b1; mem.raddr = widx(r_n);
                n_state = S_G2;
            end
            S_G2: begin
                n_w = PAGE | {15'd0, i_rdata[sfha_pkg::F_PREV], 1'b0};
                mem.we = 1'b1; mem.waddr = widx(r_n);
                mem.wdata = PAGE | {15'd0, i_rdata[sfha_pkg::F_PREV], 1'b0};
                n_state = S_G3;
            end
            S_G3: begin
                mem.we = 1'b1; mem.waddr = widx(r_n + PAGE - sfha_pkg::WORD_BYTES);
                mem.wdata = r_w;
                n_h = r_n;
                n_stk[r_sp] = S_FS; n_sp = r_sp + 2'd1;
                n_state = S_CP0;
            end

            // Place and split
            S_PL0: begin
                mem.re = 1'b1; mem.raddr = widx(r_b);
                n_state = S_PL1;
            end
            S_PL1: begin
                n_bs = ps; n_prev = i_rdata[sfha_pkg::F_PREV];
                n_h = r_b;
                n_stk[r_sp] = S_PL2; n_sp = r_sp + 2'd1;
                n_state = S_LR0;
            end
            S_PL2: begin
                mem.we = 1'b1; mem.waddr = widx(r_b);
                if (r_bs - r_asize < sfha_pkg::MIN_BLOCK) begin
                    mem.wdata = r_bs | {14'd0, 1'b1, r_prev, 1'b0};
                    n_h = r_b; n_on = 1'b1;
                    n_stk[r_sp] = S_PL5; n_sp = r_sp + 2'd1;
                    n_state = S_SN0;
                end else begin
                    mem.wdata = r_asize | {14'd0, 1'b1, r_prev, 1'b0};
                    n_n = r_b + r_asize;
                    n_sz = r_bs - r_asize;
                    n_state = S_PL3;
                end
            end
            S_PL3: begin
                mem.we = 1'b1; mem.waddr = widx(r_n); mem.wdata = r_sz | 17'd2;
                n_state = S_PL4;
            end
            S_PL4: begin
                mem.we = 1'b1; mem.waddr = widx(r_n + r_sz - sfha_pkg::WORD_BYTES);
                mem.wdata = r_sz | 17'd2;
                n_h = r_n;
                n_stk[r_sp] = S_PL5; n_sp = r_sp + 2'd1;
                n_state = S_LP0;
            end
            S_PL5: begin
                n_res = 16'(r_b + 17'd8); n_stat = sfha_pkg::ST_OK;
                n_state = S_DONE;
            end

            // Unlink block r_h from its class list
            S_LR0: begin
                mem.re = 1'b1; mem.raddr = widx(r_h);
                n_state = S_LR1;
            end
            S_LR1: begin
                n_c = cl;
                mem.re = 1'b1; mem.raddr = widx(r_h + 17'd8);
                n_state = S_LR2;
            end
            S_LR2: begin
                n_nx = i_rdata[15:0];
                mem.re = 1'b1; mem.raddr = widx(r_h + 17'd16);
                n_state = S_LR3;
            end
            S_LR3: begin
                n_pv = i_rdata[15:0];
                if (i_rdata[15:0] == 16'd0) begin
                    n_chead[r_c] = r_nx;
                end else begin
                    mem.we = 1'b1; mem.waddr = widx({1'b0, i_rdata[15:0]} + 17'd8);
                    mem.wdata = {1'b0, r_nx};
                end
                n_state = S_LR4;
            end
            S_LR4: begin
                if (r_nx != 16'd0) begin
                    mem.we = 1'b1; mem.waddr = widx({1'b0, r_nx} + 17'd16);
                    mem.wdata = {1'b0, r_pv};
                end
                n_sp = sp_m1; n_state = r_stk[sp_m1];
            end

            // Push block r_h on its class list
            S_LP0: begin
                mem.re = 1'b1; mem.raddr = widx(r_h);
                n_state = S_LP1;
            end
            S_LP1: begin
                n_c = cl;
                n_old = r_chead[cl];
                mem.we = 1'b1; mem.waddr = widx(r_h + 17'd8);
                mem.wdata = {1'b0, r_chead[cl]};
                n_state = S_LP2;
            end
            S_LP2: begin
                mem.we = 1'b1; mem.waddr = widx(r_h + 17'd16); mem.wdata = '0;
                n_state = S_LP3;
            end
            S_LP3: begin
                if (r_old != 16'd0) begin
                    mem.we = 1'b1; mem.waddr = widx({1'b0, r_old} + 17'd16);
                    mem.wdata = {1'b0, r_h[15:0]};
                end
                n_chead[r_c] = r_h[15:0];
                n_sp = sp_m1; n_state = r_stk[sp_m1];
            end

            // Set or clear the previous-allocated bit of the next block
            S_SN0: begin
                mem.re = 1'b1; mem.raddr = widx(r_h);
                n_state = S_SN1;
            end
            S_SN1: begin
                n_n = r_h + ps;
                mem.re = 1'b1; mem.raddr = widx(r_h + ps);
                n_state = S_SN2;
            end
            S_SN2: begin
                wv[sfha_pkg::F_PREV] = r_on;
                n_w = wv;
                mem.we = 1'b1; mem.waddr = widx(r_n); mem.wdata = wv;
                if (wv[sfha_pkg::F_ALLOC]) begin
                    n_sp = sp_m1; n_state = r_stk[sp_m1];
                end else begin
                    n_state = S_SN3;
                end
            end
            S_SN3: begin
                mem.we = 1'b1; mem.waddr = widx(r_n + szf(r_w) - sfha_pkg::WORD_BYTES);
                mem.wdata = r_w;
                n_sp = sp_m1; n_state = r_stk[sp_m1];
            end

            // Coalesce free block r_h with free neighbors and list it
            S_CP0: begin
                n_ch = r_h;
                mem.re = 1'b1; mem.raddr = widx(r_h);
                n_state = S_CP1;
            end
            S_CP1: begin
                n_cs = ps;
                n_h = r_ch + ps;
                mem.re = 1'b1; mem.raddr = widx(r_ch + ps);
                n_state = S_CP2;
            end
            S_CP2: begin
                if (!i_rdata[sfha_pkg::F_ALLOC]) begin
                    n_cs = r_cs + ps;
                    n_stk[r_sp] = S_CP3; n_sp = r_sp + 2'd1;
                    n_state = S_LR0;
                end else begin
                    n_state = S_CP3;
                end
            end
            S_CP3: begin
                mem.re = 1'b1; mem.raddr = widx(r_ch);
                n_state = S_CP4;
            end
            S_CP4: begin
                if (!i_rdata[sfha_pkg::F_PREV]) begin
                    mem.re = 1'b1; mem.raddr = widx(r_ch - sfha_pkg::WORD_BYTES);
                    n_state = S_CP5;
                end else begin
                    n_cst = r_ch;
                    n_state = S_CP6;
                end
            end
            S_CP5: begin
                n_cst = r_ch - ps;
                n_h = r_ch - ps;
                n_cs = r_cs + ps;
                n_stk[r_sp] = S_CP6; n_sp = r_sp + 2'd1;
                n_state = S_LR0;
            end
            S_CP6: begin
                mem.re = 1'b1; mem.raddr = widx(r_cst);
                n_state = S_CP7;
            end
            S_CP7: begin
                n_w = r_cs | {15'd0, i_rdata[sfha_pkg::F_PREV], 1'b0};
                mem.we = 1'b1; mem.waddr = widx(r_cst);
                mem.wdata = r_cs | {15'd0, i_rdata[sfha_pkg::F_PREV], 1'b0};
                n_state = S_CP8;
            end
            S_CP8: begin
                mem.we = 1'b1; mem.waddr = widx(r_cst + r_cs - sfha_pkg::WORD_BYTES);
                mem.wdata = r_w;
                n_h = r_cst;
                n_state = S_LP0;
            end

            // Release block r_h to the free lists
            S_RL0: begin
                mem.re = 1'b1; mem.raddr = widx(r_h);
                n_state = S_RL1;
            end
            S_RL1: begin
                wv[sfha_pkg::F_ALLOC] = 1'b0;
                wv[sfha_pkg::F_QUICK] = 1'b0;
                n_w = wv;
                mem.we = 1'b1; mem.waddr = widx(r_h); mem.wdata = wv;
                n_state = S_RL2;
            end
            S_RL2: begin
                mem.we = 1'b1; mem.waddr = widx(r_h + szf(r_w) - sfha_pkg::WORD_BYTES);
                mem.wdata = r_w;
                n_on = 1'b0;
                n_stk[r_sp] = S_RL3; n_sp = r_sp + 2'd1;
                n_state = S_SN0;
            end
            S_RL3: begin
                n_state = S_CP0;
            end

            // Free: validate the pointer
            S_FREE: begin
                if (r_off == 16'd0 || r_off[2:0] != 3'b000 || r_hend == '0) begin
                    n_res = '0; n_stat = sfha_pkg::ST_BADPTR; n_state = S_DONE;
                end else if (h_tmp < sfha_pkg::MIN_BLOCK || h_tmp >= {1'b0, r_epi}) begin
                    n_res = '0; n_stat = sfha_pkg::ST_BADPTR; n_state = S_DONE;
                end else begin
                    n_fh = h_tmp;
                    mem.re = 1'b1; mem.raddr = widx(h_tmp);
                    n_state = S_V1;
                end
            end
            S_V1: begin
                n_sz = ps;
                if (!i_rdata[sfha_pkg::F_ALLOC] || i_rdata[sfha_pkg::F_QUICK] ||
                    ps < sfha_pkg::MIN_BLOCK ||
                    ({1'b0, r_fh} + {1'b0, ps} > {2'b00, r_epi})) begin
                    n_res = '0; n_stat = sfha_pkg::ST_BADPTR; n_state = S_DONE;
                end else if (!i_rdata[sfha_pkg::F_PREV]) begin
                    mem.re = 1'b1; mem.raddr = widx(r_fh - sfha_pkg::WORD_BYTES);
                    n_state = S_V2;
                end else begin
                    n_state = S_V3;
                end
            end
            S_V2: begin
                if (i_rdata[sfha_pkg::F_ALLOC]) begin
                    n_res = '0; n_stat = sfha_pkg::ST_BADPTR; n_state = S_DONE;
                end else begin
                    n_state = S_V3;
                end
            end
            S_V3: begin
                qa = quick_of(r_sz);
                if (qa[QW]) begin
                    n_q = qa[QW-1:0];
                    n_state = (r_qlen[qa[QW-1:0]] >= i_qcap) ? S_FL0 : S_FL2;
                end else begin
                    n_h = r_fh;
                    n_stk[r_sp] = S_VOK; n_sp = r_sp + 2'd1;
                    n_state = S_RL0;
                end
            end
            S_VOK: begin
                n_res = '0; n_stat = sfha_pkg::ST_OK; n_state = S_DONE;
            end

            // Flush a full quick list, then push the freed block
            S_FL0: begin
                if (r_qlen[r_q] != 4'd0) begin
                    n_h = {1'b0, r_qhead[r_q]};
                    n_qlen[r_q] = r_qlen[r_q] - 4'd1;
                    mem.re = 1'b1; mem.raddr = widx({1'b0, r_qhead[r_q]} + 17'd8);
                    n_state = S_FL1;
                end else begin
                    n_state = S_FL2;
                end
            end
            S_FL1: begin
                n_qhead[r_q] = (r_qlen[r_q] != 4'd0) ? i_rdata[15:0] : 16'd0;
                n_stk[r_sp] = S_FL0; n_sp = r_sp + 2'd1;
                n_state = S_RL0;
            end
            S_FL2: begin
                mem.we = 1'b1; mem.waddr = widx(r_fh + 17'd8);
                mem.wdata = (r_qlen[r_q] != 4'd0) ? {1'b0, r_qhead[r_q]} : 17'd0;
                n_qhead[r_q] = r_fh[15:0];
                n_qlen[r_q] = r_qlen[r_q] + 4'd1;
                n_state = S_FL3;
            end
            S_FL3: begin
                mem.re = 1'b1; mem.raddr = widx(r_fh);
                n_state = S_FL4;
            end
            S_FL4: begin
                wv[sfha_pkg::F_QUICK] = 1'b1;
                mem.we = 1'b1; mem.waddr = widx(r_fh); mem.wdata = wv;
                n_state = S_VOK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_hend  <= '0;
            r_epi   <= '0;
            for (int i = 0; i < NUM_SIZE_CLASSES; i++) r_chead[i] <= '0;
            for (int i = 0; i < NUM_QUICK_SIZES; i++) begin
                r_qhead[i] <= '0;
                r_qlen[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_hend  <= n_hend;
            r_epi   <= n_epi;
            r_chead <= n_chead;
            r_qhead <= n_qhead;
            r_qlen  <= n_qlen;
        end
    end

    // Working registers, no reset
    always_ff @(posedge i_clk) begin
        r_stk <= n_stk;
        r_h <= n_h; r_n <= n_n; r_sz <= n_sz; r_w <= n_w; r_b <= n_b; r_bs <= n_bs;
        r_asize <= n_asize; r_rsz <= n_rsz; r_fh <= n_fh;
        r_ch <= n_ch; r_cs <= n_cs; r_cst <= n_cst;
        r_nx <= n_nx; r_pv <= n_pv; r_old <= n_old; r_off <= n_off; r_res <= n_res;
        r_stat <= n_stat; r_c <= n_c; r_fc <= n_fc; r_q <= n_q; r_steps <= n_steps;
        r_on <= n_on; r_prev <= n_prev;
    end

endmodule

/* rtl/segregated_fit_heap_allocator_core.sv */
// Heap allocator top: one transaction at a time. A zero-size request or a pointer rejected
// before any memory read completes without heap memory access, and a quick-list hit reads
// the next link and the header and rewrites the header; other requests take longer, walking
// free-list entries and doing unlinks, pushes and boundary-tag updates, and a flush or page
// growth adds further list and tag updates. A new request is taken the cycle
// after the result loads; an unaccepted result stalls the engine. Synchronous active-low
// reset empties all lists and marks the heap not set up; heap memory is not cleared.
module segregated_fit_heap_allocator_core #(
    parameter int PAGE_BYTES       = sfha_pkg::DEF_PAGE_BYTES,
    parameter int MAX_PAGES        = sfha_pkg::DEF_MAX_PAGES,
    parameter int NUM_QUICK_SIZES  = sfha_pkg::DEF_NUM_QUICK_SIZES,
    parameter int NUM_SIZE_CLASSES = sfha_pkg::DEF_NUM_SIZE_CLASSES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfha_req_if.sink    i_req,
    sfha_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata
);

    logic [3:0]                  r_qcap;
    logic                        r_ovalid;
    logic [15:0]                 r_ooff;
    logic [1:0]                  r_ostat;
    logic                        out_free;
    sfha_pkg::t_rsp              done;
    sfha_pkg::t_mem_req          mem_req;
    logic [sfha_pkg::WORD_W-1:0] mem_rdata;

    assign out_free = !r_ovalid || o_rsp.ready;

    sfha_engine #(
        .PAGE_BYTES       (PAGE_BYTES),
        .MAX_PAGES        (MAX_PAGES),
        .NUM_QUICK_SIZES  (NUM_QUICK_SIZES),
        .NUM_SIZE_CLASSES (NUM_SIZE_CLASSES)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_req.valid),
        .o_ready          (i_req.ready),
        .i_op             (i_req.op),
        .i_request_size   (i_req.request_size),
        .i_payload_offset (i_req.payload_offset),
        .i_qcap           (r_qcap),
        .i_out_free       (out_free),
        .o_done           (done),
        .o_mem            (mem_req),
        .i_rdata          (mem_rdata)
    );

    sfha_heap_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Hold the quick list capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcap <= sfha_pkg::QCAP_RESET;
        end else if (i_cfg_we) begin
            r_qcap <= i_cfg_wdata;
        end
    end

    // Output register: load a finished transaction, drop on handoff
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done.valid) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done.valid) begin
            r_ooff  <= done.offset;
            r_ostat <= done.status;
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.result_offset = r_ooff;
    assign o_rsp.status        = r_ostat;

endmodule
